// ----- src/rotz_pkg.sv -----
// Package for the z-axis alignment matrix core: widths, constants and the
// item and cell structs. No dependencies.
`default_nettype none
package rotz_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int F_W      = 16;
  localparam int K_W      = 16;
  localparam int S_W      = 2 * F_W;
  localparam int SQ_STEPS = S_W / 2;
  localparam int REM_W    = K_W + 1;
  localparam int D_W      = K_W + 1;
  localparam int Q_W      = FRAC_BITS + 1;
  localparam int N_W      = ((F_W + FRAC_BITS > S_W - 1) ? F_W + FRAC_BITS : S_W - 1) + 1;
  localparam int C_W      = D_W + FRAC_BITS + 1;
  localparam int CMP_W    = (N_W > C_W) ? N_W : C_W;
  localparam int LANES    = 4;

  localparam int TOL_W  = 10;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_ZERO_TOL = 1'b0;
  localparam logic [TOL_W-1:0]  TOL_RESET    = 10'd1;

  // lane order of the divider: m00, m01, m10, m11
  localparam int L_M00 = 0;
  localparam int L_M01 = 1;
  localparam int L_M10 = 2;
  localparam int L_M11 = 3;

  typedef struct packed {
    logic signed [F_W-1:0] vec_x;
    logic signed [F_W-1:0] vec_y;
    logic signed [F_W-1:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [F_W-1:0] m00;
    logic signed [F_W-1:0] m01;
    logic signed [F_W-1:0] m02;
    logic signed [F_W-1:0] m10;
    logic signed [F_W-1:0] m11;
    logic signed [F_W-1:0] m12;
    logic signed [F_W-1:0] m20;
    logic signed [F_W-1:0] m21;
    logic signed [F_W-1:0] m22;
    logic                  degenerate;
  } out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [K_W-1:0]   root;
    logic [S_W-1:0]   sbits;
  } sq_t;

  typedef struct packed {
    logic [D_W-1:0]                  d;
    logic [LANES-1:0][D_W-1:0]       p;
    logic [LANES-1:0][Q_W-1:0]       nr;
    logic [LANES-1:0][Q_W-1:0]       q;
  } dv_t;

  typedef struct packed {
    logic signed [F_W-1:0] x;
    logic signed [F_W-1:0] y;
    logic signed [F_W-1:0] z;
    logic signed [S_W-1:0] xz;
    logic signed [S_W-1:0] yz;
    logic                  deg;
  } sside_t;

  typedef struct packed {
    logic signed [F_W-1:0] x;
    logic signed [F_W-1:0] y;
    logic signed [F_W-1:0] z;
    logic [K_W-1:0]        k;
    logic                  deg;
    logic [LANES-1:0]      sat;
    logic [LANES-1:0]      neg;
  } fside_t;

endpackage
`default_nettype wire

// ----- src/rotz_sqrt_cell.sv -----
// One cell of the square root chain: resolves one root bit per
// cycle while en is high. Depends on rotz_pkg.
`default_nettype none
module rotz_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  rotz_pkg::sq_t din,
  output rotz_pkg::sq_t dout
);
  import rotz_pkg::*;

  logic [REM_W+1:0] cur;
  logic [REM_W:0]   trial;
  sq_t              dout_next;

  always_comb begin
    cur   = {din.rem, din.sbits[S_W-1 -: 2]};
    trial = {din.root, 2'b01};
    dout_next.sbits = {din.sbits[S_W-3:0], 2'b00};
    if (cur >= {1'b0, trial}) begin
      dout_next.rem  = REM_W'(cur - {1'b0, trial});
      dout_next.root = {din.root[K_W-2:0], 1'b1};
    end else begin
      dout_next.rem  = REM_W'(cur);
      dout_next.root = {din.root[K_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/rotz_div_cell.sv -----
// One cell of the divider chain: one quotient bit per cycle while en
// is high, for all four lanes, sharing one divisor. Depends on rotz_pkg.
`default_nettype none
module rotz_div_cell (
  input  logic          clk,
  input  logic          en,
  input  rotz_pkg::dv_t din,
  output rotz_pkg::dv_t dout
);
  import rotz_pkg::*;

  logic [D_W:0] cur;
  dv_t          dout_next;

  always_comb begin
    dout_next.d = din.d;
    for (int i = 0; i < LANES; i++) begin
      cur = {din.p[i], din.nr[i][Q_W-1]};
      dout_next.nr[i] = {din.nr[i][Q_W-2:0], 1'b0};
      if (cur >= {1'b0, din.d}) begin
        dout_next.p[i] = D_W'(cur - {1'b0, din.d});
        dout_next.q[i] = {din.q[i][Q_W-2:0], 1'b1};
      end else begin
        dout_next.p[i] = D_W'(cur);
        dout_next.q[i] = {din.q[i][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/rotate_unit_vector_into_z_matrix_core.sv -----
// Matrix that rotates a unit vector onto the z axis.
// Pipeline: the square root cell chain (one root bit per cell), then the divider
// cell chain (one quotient bit per cell). Throughput: one item per cycle while
// the skid register is empty; the skid register takes one item while out stalls.
// Reset: synchronous; empties the pipeline and sets zero_tolerance to 1.
`default_nettype none
module rotate_unit_vector_into_z_matrix_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rotz_pkg::ADDR_W-1:0]     paddr,
  input  logic [rotz_pkg::DATA_W-1:0]     pwdata,
  output logic [rotz_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rotz_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rotz_pkg::out_t                  out_data
);
  import rotz_pkg::*;

  logic [TOL_W-1:0] zero_tol;
  logic             en;
  logic             accept;

  logic                  a_valid;
  logic signed [F_W-1:0] a_x, a_y, a_z;

  logic                  b_valid;
  logic signed [S_W-1:0] b_xx, b_yy;
  sside_t                b_side;

  logic                  c_valid;
  logic [S_W-1:0]        c_s;
  sside_t                c_side;

  sq_t                   sq_d    [SQ_STEPS+1];
  sside_t                sq_side [SQ_STEPS];
  logic [SQ_STEPS-1:0]   sq_valid;

  logic                  r_valid;
  logic [K_W-1:0]        r_k;
  sside_t                r_side;

  logic [F_W-1:0]              ax, ay;
  logic [S_W-1:0]              axz, ayz;
  logic [LANES-1:0][N_W-1:0]   num, nn;
  logic [D_W-1:0]              dd;
  logic [CMP_W-1:0]            lim;
  dv_t                         p_next;
  fside_t                      p_side_next;

  logic                  p_valid;
  fside_t                p_side;
  dv_t                   dv_d    [Q_W+1];
  fside_t                dv_side [Q_W];
  logic [Q_W-1:0]        dv_valid;

  logic [LANES-1:0][Q_W-1:0] qv;
  logic [LANES-1:0][F_W-1:0] mv;
  logic [K_W-1:0]            kmin;
  out_t                      fin;
  logic                      last_valid;

  logic skid_valid;
  out_t skid_data;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tol <= TOL_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_ZERO_TOL) begin
      zero_tol <= pwdata[TOL_W-1:0];
    end
  end
  assign prdata = (paddr[ADDR_W-1:2] == REG_ZERO_TOL) ? DATA_W'(zero_tol) : '0;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign accept   = in_valid && en;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      sq_valid <= '0;
      r_valid  <= 1'b0;
      p_valid  <= 1'b0;
      dv_valid <= '0;
    end else if (en) begin
      a_valid  <= accept;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      sq_valid <= {sq_valid[SQ_STEPS-2:0], c_valid};
      r_valid  <= sq_valid[SQ_STEPS-1];
      p_valid  <= r_valid;
      dv_valid <= {dv_valid[Q_W-2:0], p_valid};
    end
  end

  // capture, products, sum
  always_ff @(posedge clk) begin
    if (en) begin
      a_x <= in_data.vec_x;
      a_y <= in_data.vec_y;
      a_z <= in_data.vec_z;
      b_xx       <= a_x * a_x;
      b_yy       <= a_y * a_y;
      b_side.x   <= a_x;
      b_side.y   <= a_y;
      b_side.z   <= a_z;
      b_side.xz  <= a_x * a_z;
      b_side.yz  <= a_y * a_z;
      b_side.deg <= ($signed({a_x[F_W-1], a_x}) <= $signed({7'b0, zero_tol})) &&
                    ($signed({a_x[F_W-1], a_x}) >= -$signed({7'b0, zero_tol})) &&
                    ($signed({a_y[F_W-1], a_y}) <= $signed({7'b0, zero_tol})) &&
                    ($signed({a_y[F_W-1], a_y}) >= -$signed({7'b0, zero_tol}));
      c_s    <= unsigned'(b_xx + b_yy);
      c_side <= b_side;
    end
  end

  // square root chain
  assign sq_d[0] = '{rem: '0, root: '0, sbits: c_s};
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    rotz_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq_d[i]),
      .dout (sq_d[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= c_side;
      for (int i = 1; i < SQ_STEPS; i++) begin
        sq_side[i] <= sq_side[i-1];
      end
      r_k    <= K_W'(sq_d[SQ_STEPS].root +
                     K_W'(sq_d[SQ_STEPS].rem > REM_W'(sq_d[SQ_STEPS].root)));
      r_side <= sq_side[SQ_STEPS-1];
    end
  end

  // divider setup: N = 2|n| + k, D = 2k
  always_comb begin
    ax  = r_side.x[F_W-1] ? F_W'(-r_side.x) : F_W'(r_side.x);
    ay  = r_side.y[F_W-1] ? F_W'(-r_side.y) : F_W'(r_side.y);
    axz = r_side.xz[S_W-1] ? S_W'(-r_side.xz) : S_W'(r_side.xz);
    ayz = r_side.yz[S_W-1] ? S_W'(-r_side.yz) : S_W'(r_side.yz);
    num[L_M00] = N_W'(ay) << FRAC_BITS;
    num[L_M01] = N_W'(ax) << FRAC_BITS;
    num[L_M10] = N_W'(axz);
    num[L_M11] = N_W'(ayz);
    dd  = {r_k, 1'b0};
    lim = (CMP_W'(dd) << FRAC_BITS) + CMP_W'(dd);
    p_next.d = dd;
    for (int i = 0; i < LANES; i++) begin
      nn[i] = N_W'((num[i] << 1) + N_W'(r_k));
      p_next.p[i]  = D_W'(nn[i] >> Q_W);
      p_next.nr[i] = nn[i][Q_W-1:0];
      p_next.q[i]  = '0;
      p_side_next.sat[i] = CMP_W'(nn[i]) >= lim;
    end
    p_side_next.neg[L_M00] = r_side.y[F_W-1];
    p_side_next.neg[L_M01] = !r_side.x[F_W-1] && (r_side.x != '0);
    p_side_next.neg[L_M10] = r_side.xz[S_W-1];
    p_side_next.neg[L_M11] = r_side.yz[S_W-1];
    p_side_next.x   = r_side.x;
    p_side_next.y   = r_side.y;
    p_side_next.z   = r_side.z;
    p_side_next.k   = r_k;
    p_side_next.deg = r_side.deg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d[0] <= p_next;
      p_side  <= p_side_next;
      dv_side[0] <= p_side;
      for (int i = 1; i < Q_W; i++) begin
        dv_side[i] <= dv_side[i-1];
      end
    end
  end

  // divider chain
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    rotz_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (dv_d[i]),
      .dout (dv_d[i+1])
    );
  end

  // assemble the result
  assign last_valid = dv_valid[Q_W-1];
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qv[i] = dv_side[Q_W-1].sat[i] ? Q_W'(ONE) : dv_d[Q_W].q[i];
      mv[i] = dv_side[Q_W-1].neg[i] ? F_W'(-{1'b0, qv[i]}) : F_W'({1'b0, qv[i]});
    end
    kmin = (dv_side[Q_W-1].k > K_W'(ONE)) ? K_W'(ONE) : dv_side[Q_W-1].k;
    fin.m02        = '0;
    fin.m22        = dv_side[Q_W-1].z;
    fin.degenerate = dv_side[Q_W-1].deg;
    if (dv_side[Q_W-1].deg) begin
      fin.m00 = F_W'(ONE);
      fin.m01 = '0;
      fin.m10 = '0;
      fin.m11 = F_W'(ONE);
      fin.m12 = '0;
      fin.m20 = '0;
      fin.m21 = '0;
    end else begin
      fin.m00 = mv[L_M00];
      fin.m01 = mv[L_M01];
      fin.m10 = mv[L_M10];
      fin.m11 = mv[L_M11];
      fin.m12 = F_W'(-{1'b0, kmin});
      fin.m20 = dv_side[Q_W-1].x;
      fin.m21 = dv_side[Q_W-1].y;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && out_stall) begin
      skid_valid <= last_valid;
    end else begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_data <= skid_data;
      end
    end else if (out_valid && out_stall) begin
      skid_data <= fin;
    end else begin
      out_data <= fin;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  a_m02_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.m02 == '0)
    else $error("m02 not zero");

  a_degen_rows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.m20 == '0 && out_data.m21 == '0 && out_data.m12 == '0)
    else $error("degenerate result carries nonzero off-diagonal entries");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for rotate_unit_vector_into_z_matrix_core: random and directed vectors,
// expected matrices predicted in SystemVerilog. Depends on rotz_pkg and the core.
module tb;
  import rotz_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  rotate_unit_vector_into_z_matrix_core DUT (.*);

  always #4 clk = ~clk;

  out_t matrix_q[$];
  int unsigned tol = 1;
  int unsigned send_idle = 0, recv_idle = 0;
  int errors = 0;
  int quiet = 0;

  function automatic longint sat_unit(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint n, q;
    n = num < 0 ? -num : num;
    q = (2 * n + den) / (2 * den);
    return sat_unit(num < 0 ? -q : q);
  endfunction

  function automatic longint root_nearest(longint s);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic out_t rotation_of(in_t v);
    out_t m;
    longint x, y, z, k;
    x = v.vec_x; y = v.vec_y; z = v.vec_z;
    m = '0;
    m.m22 = v.vec_z;
    if ((x < 0 ? -x : x) <= tol && (y < 0 ? -y : y) <= tol) begin
      m.degenerate = 1'b1;
      m.m00 = F_W'(ONE);
      m.m11 = F_W'(ONE);
    end else begin
      k = root_nearest(x * x + y * y);
      m.m00 = F_W'(round_div(y * ONE, k));
      m.m01 = F_W'(round_div(-x * ONE, k));
      m.m10 = F_W'(round_div(x * z, k));
      m.m11 = F_W'(round_div(y * z, k));
      m.m12 = F_W'(sat_unit(-k));
      m.m20 = v.vec_x;
      m.m21 = v.vec_y;
    end
    return m;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);
    if (!rst && out_valid && !out_stall) begin
      if (matrix_q.size() == 0) begin
        $display("%0t unexpected matrix %h", $time, out_data);
        errors++;
      end else if (matrix_q[0] !== out_data) begin
        $display("%0t mismatch: expected %h actual %h", $time, matrix_q[0], out_data);
        errors++;
        void'(matrix_q.pop_front());
      end else begin
        void'(matrix_q.pop_front());
      end
    end
  end

  task automatic send_vector(in_t v);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    matrix_q.push_back(rotation_of(v));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_tolerance(int unsigned t);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_ZERO_TOL, 2'b00}; pwdata <= t;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tol = t;
  endtask

  function automatic in_t mk(int x, int y, int z);
    in_t v;
    v.vec_x = F_W'(x); v.vec_y = F_W'(y); v.vec_z = F_W'(z);
    return v;
  endfunction

  function automatic in_t random_vector();
    int sel;
    real a, b, c, n;
    sel = $urandom_range(9);
    if (sel < 6) begin
      a = $urandom_range(2000) - 1000.0;
      b = $urandom_range(2000) - 1000.0;
      c = $urandom_range(2000) - 1000.0;
      n = $sqrt(a * a + b * b + c * c);
      if (n < 1.0) n = 1.0;
      return mk($rtoi(a / n * ONE), $rtoi(b / n * ONE), $rtoi(c / n * ONE));
    end else if (sel < 8) begin
      return mk($urandom_range(2 * tol + 4) - tol - 2,
                $urandom_range(2 * tol + 4) - tol - 2, $urandom_range(32768) - 16384);
    end
    return in_t'(48'({$urandom, $urandom}));
  endfunction

  task automatic test_directed;
    send_vector(mk(0, 0, ONE));
    send_vector(mk(0, 0, -ONE));
    send_vector(mk(1, -1, 0));
    send_vector(mk(2, 0, 7));
    send_vector(mk(0, -2, 7));
    send_vector(mk(ONE, 0, 0));
    send_vector(mk(-ONE, 0, 0));
    send_vector(mk(0, ONE, 0));
    send_vector(mk(0, -ONE, 0));
    send_vector(mk(11585, 11585, 0));
    send_vector(mk(9459, -9459, 9459));
    send_vector(mk(-32768, -32768, -32768));
    send_vector(mk(32767, 32767, 32767));
    send_vector(mk(-32768, 32767, 1));
    send_vector(mk(3, 4, 32767));
    send_vector(mk(-1, 1, -32768));
    send_vector(mk(16'hAAAA, 16'h5555, 16'hFFFF));
    drain();
  endtask

  task automatic test_tolerance_extremes;
    write_tolerance(0);
    send_vector(mk(0, 0, 5));
    send_vector(mk(1, 0, 5));
    send_vector(mk(0, -1, 5));
    drain();
    write_tolerance(1023);
    send_vector(mk(1023, -1023, 100));
    send_vector(mk(1024, 0, 100));
    send_vector(mk(-1023, -1024, 100));
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_vector(random_vector());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_tolerance_extremes();
    write_tolerance(1);
    send_idle = 32; recv_idle = 81;
    test_random(650);
    drain();
    write_tolerance($urandom_range(1022, 2));
    send_idle = 81; recv_idle = 32;
    test_random(650);
    drain();
    write_tolerance(300);
    send_idle = 0; recv_idle = 0;
    test_random(600);
    drain();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
